// ===== hw/rtl/bmag_pkg.sv =====
package bmag_pkg;

    // Ring depth and field widths.
    localparam int SAMPLE_COUNT = 16;
    localparam int CODE_W       = 12;
    localparam int MV_W         = 14;
    localparam int PCT_W        = 7;
    localparam int CFG_W        = 14;
    localparam int CFG_IDX_W    = 2;
    localparam int HELD_W       = $clog2(SAMPLE_COUNT + 1);
    localparam int SLOT_W       = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;

    // Scale: code 4095 reads as 12000 mV.
    localparam int CODE_FULL_SCALE = 4095;
    localparam int MV_FULL_SCALE   = 12000;
    localparam int MV_SCALE2       = 2 * MV_FULL_SCALE;
    localparam int PCT_MAX         = 100;
    localparam int PCT_SCALE2      = 2 * PCT_MAX;

    localparam int SUM_W = $clog2(SAMPLE_COUNT * CODE_FULL_SCALE + 1);

    // Mean division: (2*sum*12000 + 4095*held) / (2*4095*held).
    localparam longint NUM1_MAX = longint'(SAMPLE_COUNT) * CODE_FULL_SCALE * MV_SCALE2
                                + longint'(SAMPLE_COUNT) * CODE_FULL_SCALE;
    localparam int NUM1_W  = $clog2(NUM1_MAX + 1);
    localparam int DEN1_W  = $clog2(2 * CODE_FULL_SCALE * SAMPLE_COUNT + 1);

    // Percentage division: (200*(mv-empty) + span) / (2*span).
    localparam int NUM2_W  = $clog2(MV_FULL_SCALE * PCT_SCALE2 + (2 ** CFG_W));
    localparam int DEN2_W  = CFG_W + 1;

    localparam int DEN_W   = (DEN1_W > DEN2_W) ? DEN1_W : DEN2_W;
    localparam int REM_W   = DEN_W + 1;
    localparam int CNT_W   = $clog2(MV_W);

    // Stream word widths, padded to whole bytes.
    localparam int IN_TDATA_W   = ((CODE_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = MV_W + PCT_W + HELD_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MV  = CFG_IDX_W'(1);
    localparam logic [CFG_W-1:0]     EMPTY_MV_RST = CFG_W'(3000);
    localparam logic [CFG_W-1:0]     FULL_MV_RST  = CFG_W'(4200);

endpackage

// ===== hw/rtl/battery_moving_average_gauge_unit.sv =====
// Channel      | Direction | Word contents (lowest bit first)
// -------------|-----------|------------------------------------------------------
// s_axis       | in        | tdata: adc_code[11:0], zero pad to 16 bits
// m_axis       | out       | tdata: average_millivolts[13:0], charge_percent[20:14],
//              |           |        samples_held[25:21], zero pad to 32 bits
// cfg          | in        | index 0 empty_millivolts, 1 full_millivolts; data 14 bits
//
// An accepted word passes ring update, scaling, 14 divider steps for the mean, percentage
// setup, saturation check, 7 divider steps for the percentage and result selection before
// the output register loads; the percentage steps are skipped when no division is needed.
// Reset (synchronous, active low) clears the sum and fill count; the ring memory is
// not cleared, as a slot's read data is used only after the slot has been written.
// A stalled output holds its word while the next sample is already taken in.
module battery_moving_average_gauge_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Sample input.
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [bmag_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,   // adc_code
    // Result output.
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [bmag_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,   // average_millivolts,
                                                                 // charge_percent,
                                                                 // samples_held
    // Configuration writes.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bmag_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bmag_pkg::CFG_W-1:0]         i_cfg_data
);
    import bmag_pkg::*;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a sample word
    localparam logic [2:0] ST_UPD  = 3'd1;  // ring write and sum update
    localparam logic [2:0] ST_MUL  = 3'd2;  // scale sum, load mean division
    localparam logic [2:0] ST_DIV1 = 3'd3;  // mean division steps
    localparam logic [2:0] ST_PCT  = 3'd4;  // percentage operands and special cases
    localparam logic [2:0] ST_CHK  = 3'd5;  // saturation check, load second division
    localparam logic [2:0] ST_DIV2 = 3'd6;  // percentage division steps
    localparam logic [2:0] ST_DONE = 3'd7;  // hand the result to the output register

    logic [2:0]        r_state;
    logic [2:0]        n_state;

    // Configuration registers.
    logic [CFG_W-1:0]  r_empty_mv;
    logic [CFG_W-1:0]  r_full_mv;

    // Ring state. The ring lives in a synchronous memory with registered read data.
    logic [CODE_W-1:0] r_ring [SAMPLE_COUNT];
    logic [CODE_W-1:0] r_rd_data;
    logic [CODE_W-1:0] r_code;
    logic [SUM_W-1:0]  r_sum;
    logic [SLOT_W-1:0] r_slot;
    logic [HELD_W-1:0] r_fill;

    // Shared divider.
    logic [REM_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [MV_W-1:0]   r_quo;
    logic [CNT_W-1:0]  r_cnt;

    // Percentage stage.
    logic [MV_W-1:0]   r_mv;
    logic [NUM2_W-1:0] r_num2;
    logic              r_special;
    logic              r_use_quo;
    logic [PCT_W-1:0]  r_pct;

    // Output register.
    logic              r_out_valid;
    logic [MV_W-1:0]   r_out_mv;
    logic [PCT_W-1:0]  r_out_pct;
    logic [HELD_W-1:0] r_out_held;

    logic              in_acc;
    logic              out_acc;
    logic              out_free;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc         = r_out_valid && i_m_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_held, r_out_pct, r_out_mv});

    // One restoring division step: bring in the next dividend bit, subtract if it fits.
    logic [REM_W-1:0]  div_shift;
    logic              div_fits;
    logic [REM_W-1:0]  div_rem;

    always_comb begin
        div_shift = {r_rem[REM_W-2:0], r_quo[MV_W-1]};
        div_fits  = (div_shift >= REM_W'(r_den));
        div_rem   = div_fits ? (div_shift - REM_W'(r_den)) : div_shift;
    end

    // Mean scaling: numerator and denominator of the rounded mean.
    logic [NUM1_W-1:0] mean_num;
    logic [DEN_W-1:0]  mean_den;

    always_comb begin
        mean_num = NUM1_W'(r_sum) * NUM1_W'(MV_SCALE2)
                 + NUM1_W'(r_fill) * NUM1_W'(CODE_FULL_SCALE);
        mean_den = DEN_W'(r_fill) * DEN_W'(2 * CODE_FULL_SCALE);
    end

    // Percentage operands, taken from the rounded mean left in the quotient register.
    logic [CFG_W-1:0]  pct_span;
    logic [MV_W-1:0]   pct_diff;
    logic [NUM2_W-1:0] pct_num;
    logic              pct_no_scale;
    logic              pct_below;

    always_comb begin
        pct_span     = r_full_mv - r_empty_mv;
        pct_diff     = r_quo - MV_W'(r_empty_mv);
        pct_num      = NUM2_W'(pct_diff) * NUM2_W'(PCT_SCALE2) + NUM2_W'(pct_span);
        pct_no_scale = (r_full_mv <= r_empty_mv);
        pct_below    = (CFG_W'(r_quo) <= r_empty_mv);
    end

    // A quotient of 128 or more is certainly above one hundred percent.
    logic              pct_saturates;
    assign pct_saturates = ({r_num2, {PCT_W{1'b0}}} >=
                            {(NUM2_W)'(r_den), {PCT_W{1'b0}}} << PCT_W);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_acc) n_state = ST_UPD;
            ST_UPD:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_DIV1;
            ST_DIV1: if (r_cnt == CNT_W'(MV_W - 1)) n_state = ST_PCT;
            ST_PCT:  n_state = ST_CHK;
            ST_CHK:  n_state = (r_special || pct_saturates) ? ST_DONE : ST_DIV2;
            ST_DIV2: if (r_cnt == CNT_W'(PCT_W - 1)) n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Ring memory: read at acceptance, written back in the cycle after, in the ring update. The sequencer
    // keeps a single word in flight, so a read never overlaps a write of the same slot.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_data <= r_ring[r_slot];
        end
        if (r_state == ST_UPD) begin
            r_ring[r_slot] <= r_code;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_empty_mv  <= EMPTY_MV_RST;
            r_full_mv   <= FULL_MV_RST;
            r_sum       <= '0;
            r_slot      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_EMPTY_MV: r_empty_mv <= i_cfg_data;
                    REG_FULL_MV:  r_full_mv  <= i_cfg_data;
                    default:      ;
                endcase
            end

            if (r_state == ST_UPD) begin
                if (r_fill < HELD_W'(SAMPLE_COUNT)) begin
                    r_fill <= r_fill + HELD_W'(1);
                    r_sum  <= r_sum + SUM_W'(r_code);
                end else begin
                    r_sum  <= r_sum - SUM_W'(r_rd_data) + SUM_W'(r_code);
                end
                if (r_slot == SLOT_W'(SAMPLE_COUNT - 1)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + SLOT_W'(1);
                end
            end

            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_code <= i_s_axis_tdata[CODE_W-1:0];
        end

        case (r_state)
            ST_MUL: begin
                r_rem <= REM_W'(mean_num >> MV_W);
                r_quo <= mean_num[MV_W-1:0];
                r_den <= mean_den;
                r_cnt <= '0;
            end
            ST_DIV1, ST_DIV2: begin
                r_rem <= div_rem;
                r_quo <= {r_quo[MV_W-2:0], div_fits};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            ST_PCT: begin
                r_mv      <= r_quo;
                r_num2    <= pct_num;
                r_den     <= DEN_W'({pct_span, 1'b0});
                r_special <= pct_no_scale || pct_below;
                if (pct_no_scale) begin
                    r_pct <= pct_below && (r_quo != MV_W'(r_empty_mv))
                             ? '0 : PCT_W'(PCT_MAX);
                end else begin
                    r_pct <= '0;
                end
            end
            ST_CHK: begin
                r_use_quo <= !(r_special || pct_saturates);
                if (!r_special && pct_saturates) begin
                    r_pct <= PCT_W'(PCT_MAX);
                end
                r_rem <= REM_W'(r_num2 >> PCT_W);
                r_quo <= MV_W'({r_num2[PCT_W-1:0], {(MV_W - PCT_W){1'b0}}});
                r_cnt <= '0;
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out_mv   <= r_mv;
                    r_out_held <= r_fill;
                    if (r_use_quo) begin
                        r_out_pct <= (r_quo[PCT_W-1:0] > PCT_W'(PCT_MAX))
                                     ? PCT_W'(PCT_MAX) : r_quo[PCT_W-1:0];
                    end else begin
                        r_out_pct <= r_pct;
                    end
                end
            end
            default: ;
        endcase
    end

    // The fill count never passes the ring depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= HELD_W'(SAMPLE_COUNT))
        else $error("fill count beyond ring depth");

    // The running sum stays within what the held codes can add up to.
    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_sum) <= int'(r_fill) * CODE_FULL_SCALE)
        else $error("running sum exceeds held codes");

    // An accepted word moves on to its ring update with the input closed.
    a_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_UPD) && !o_s_axis_tready)
        else $error("input open during ring update");

    // A presented result holds a sample count of one through the ring depth.
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_held != '0) && (r_out_held <= HELD_W'(SAMPLE_COUNT)))
        else $error("sample count out of range");

    // A presented percentage never exceeds one hundred.
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_pct <= PCT_W'(PCT_MAX)))
        else $error("charge percentage above one hundred");

endmodule
